### rtl/fixed_point_pi_controller_defines.svh
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef FIXED_POINT_PI_CONTROLLER_DEFINES_SVH
`define FIXED_POINT_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define FPIC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FPIC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fpic_pkg.sv
`timescale 1ns / 1ps

package fpic_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int INTEG_W  = 32;
  localparam int PROD_W   = 32;
  localparam int PROP_SHIFT  = 8;
  localparam int INTEG_SHIFT = 16;
  // width of proportional term plus integral term, one guard bit
  localparam int SUM_W = PROD_W - PROP_SHIFT + 1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_PROP_GAIN  = 2'd0;
  localparam reg_idx_t REG_INTEG_GAIN = 2'd1;
  localparam reg_idx_t REG_OUT_MIN    = 2'd2;
  localparam reg_idx_t REG_OUT_MAX    = 2'd3;

  typedef logic [1:0] limit_t;
  localparam limit_t LIMIT_NONE = 2'd0;
  localparam limit_t LIMIT_MIN  = 2'd1;
  localparam limit_t LIMIT_MAX  = 2'd2;
  localparam limit_t LIMIT_BAD  = 2'd3;

  localparam logic signed [GAIN_W-1:0]   PROP_GAIN_RST  = 16'sd0;
  localparam logic signed [GAIN_W-1:0]   INTEG_GAIN_RST = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN_RST    = -16'sd32768;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX_RST    = 16'sd32767;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7fff_ffff;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    limit_t                     limit;
    logic signed [INTEG_W-1:0]  integ;
  } step_res_t;

endpackage

### rtl/fpic_step.sv
`timescale 1ns / 1ps

// Integrator update, output sum, clamp and anti-windup for one sample.
module fpic_step
  import fpic_pkg::*;
(
  input  logic signed [INTEG_W-1:0]  integ_cur,
  input  logic signed [PROD_W-1:0]   prop_prod,
  input  logic signed [PROD_W-1:0]   integ_prod,
  input  logic signed [SAMPLE_W-1:0] out_min,
  input  logic signed [SAMPLE_W-1:0] out_max,
  output step_res_t                  res
);

  logic signed [INTEG_W:0]   acc_wide;
  logic signed [INTEG_W-1:0] acc_sat;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [SUM_W-1:0]   lo_ext;
  logic signed [SUM_W-1:0]   hi_ext;

  assign acc_wide = {integ_cur[INTEG_W-1], integ_cur} + {integ_prod[PROD_W-1], integ_prod};

  // overflow when the two top bits disagree; the top bit gives the direction
  always_comb begin
    if (acc_wide[INTEG_W] != acc_wide[INTEG_W-1]) begin
      acc_sat = acc_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      acc_sat = acc_wide[INTEG_W-1:0];
    end
  end

  // arithmetic shifts are just the upper slices, sign extended
  assign y_sum = SUM_W'($signed(prop_prod[PROD_W-1:PROP_SHIFT]))
               + SUM_W'($signed(acc_sat[INTEG_W-1:INTEG_SHIFT]));
  assign lo_ext = SUM_W'(out_min);
  assign hi_ext = SUM_W'(out_max);

  always_comb begin
    res.drive = y_sum[SAMPLE_W-1:0];
    res.limit = LIMIT_NONE;
    res.integ = acc_sat;
    if (y_sum < lo_ext) begin
      res.drive = out_min;
      res.limit = LIMIT_MIN;
      if (acc_sat < integ_cur) begin
        res.integ = integ_cur;
      end
    end else if (y_sum > hi_ext) begin
      res.drive = out_max;
      res.limit = LIMIT_MAX;
      if (acc_sat > integ_cur) begin
        res.integ = integ_cur;
      end
    end
  end

endmodule

### rtl/fixed_point_pi_controller.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_err_sample (s16)
// out_     | output    | out_valid/out_stall| out_drive_out (s16), out_limit_hit (2)
// cfg_     | APB slave | psel/penable       | 4 regs at 4*i, pready tied high
//
// One sample per cycle with out_stall low; out_valid rises as drive_r is loaded.
// The first stage registers both gain products, the second stage updates the
// integrator and clamps the output into the result register.
// Synchronous active-low reset: integrator zero, gains zero, limits full range.
// out_stall backs up through the two stages; in_stall rises only when both are full.
module fixed_point_pi_controller
  import fpic_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_err_sample,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_drive_out,
  output logic [1:0]                  out_limit_hit,

  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  logic signed [GAIN_W-1:0]   prop_gain_r;
  logic signed [GAIN_W-1:0]   integ_gain_r;
  logic signed [SAMPLE_W-1:0] out_min_r;
  logic signed [SAMPLE_W-1:0] out_max_r;
  logic signed [INTEG_W-1:0]  integ_r;

  logic                       prod_vld_r;
  logic signed [PROD_W-1:0]   prop_prod_r;
  logic signed [PROD_W-1:0]   integ_prod_r;
  logic signed [PROD_W-1:0]   prop_prod_nxt;
  logic signed [PROD_W-1:0]   integ_prod_nxt;

  logic                       out_vld_r;
  logic signed [SAMPLE_W-1:0] drive_r;
  limit_t                     limit_r;

  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;
  logic signed [GAIN_W-1:0]   cfg_val;
  logic signed [GAIN_W-1:0]   rd_val;

  logic                       out_free;
  logic                       prod_adv;
  logic                       prod_free;
  logic                       in_take;
  step_res_t                  step_res;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_val    = cfg_pwdata[GAIN_W-1:0];

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  rd_val = prop_gain_r;
      REG_INTEG_GAIN: rd_val = integ_gain_r;
      REG_OUT_MIN:    rd_val = out_min_r;
      REG_OUT_MAX:    rd_val = out_max_r;
      default:        rd_val = prop_gain_r;
    endcase
  end
  assign cfg_prdata = CFG_DATA_W'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      out_min_r    <= OUT_MIN_RST;
      out_max_r    <= OUT_MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_val;
        REG_INTEG_GAIN: integ_gain_r <= cfg_val;
        REG_OUT_MIN:    out_min_r    <= cfg_val;
        REG_OUT_MAX:    out_max_r    <= cfg_val;
        default:        prop_gain_r  <= prop_gain_r;
      endcase
    end
  end

  // ---------------- flow control ----------------
  assign out_free  = !out_vld_r || !out_stall;
  assign prod_adv  = prod_vld_r && out_free;
  assign prod_free = !prod_vld_r || out_free;
  assign in_stall  = !prod_free;
  assign in_take   = in_valid && prod_free;

  // ---------------- stage 1: products ----------------
  assign prop_prod_nxt  = PROD_W'(in_err_sample) * PROD_W'(prop_gain_r);
  assign integ_prod_nxt = PROD_W'(in_err_sample) * PROD_W'(integ_gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (prod_free) begin
      prod_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      prop_prod_r  <= prop_prod_nxt;
      integ_prod_r <= integ_prod_nxt;
    end
  end

  // ---------------- stage 2: integrate and clamp ----------------
  fpic_step u_step (
    .integ_cur  (integ_r),
    .prop_prod  (prop_prod_r),
    .integ_prod (integ_prod_r),
    .out_min    (out_min_r),
    .out_max    (out_max_r),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cfg_wr && cfg_idx == REG_INTEG_GAIN && cfg_val == '0) begin
      // a zero integral gain write always clears the integrator
      integ_r <= '0;
    end else if (prod_adv) begin
      integ_r <= step_res.integ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv) begin
      drive_r <= step_res.drive;
      limit_r <= step_res.limit;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_drive_out = drive_r;
  assign out_limit_hit = limit_r;

endmodule

### rtl/fpic_checker.sv
`timescale 1ns / 1ps
`include "fixed_point_pi_controller_defines.svh"

module fpic_checker
  import fpic_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_drive_out,
  input logic [1:0]                 out_limit_hit,
  input logic [CFG_DATA_W-1:0]      cfg_prdata
);

  `FPIC_ASSERT_IMP(a_no_bad_limit, out_valid, out_limit_hit != LIMIT_BAD, "limit code 3 on output")
  `FPIC_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall, "input stalled with room in the pipe")
  `FPIC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_drive_out) && $stable(out_limit_hit), "stalled result changed")
  `FPIC_ASSERT_IMP(a_rd_sext, 1'b1, cfg_prdata[CFG_DATA_W-1:SAMPLE_W] == {(CFG_DATA_W-SAMPLE_W){cfg_prdata[SAMPLE_W-1]}}, "register read not sign extended")

endmodule

bind fixed_point_pi_controller fpic_checker u_fpic_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_drive_out (out_drive_out),
  .out_limit_hit (out_limit_hit),
  .cfg_prdata    (cfg_prdata)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import fpic_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    limit_t                     limit;
  } drive_t;

  typedef struct {
    bit                         is_cfg;
    reg_idx_t                   idx;
    logic signed [15:0]         val;
    bit                         known;
    logic signed [SAMPLE_W-1:0] drive;
    limit_t                     lim;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_err_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_drive_out;
  logic [1:0]                  out_limit_hit;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]       cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]       cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]       cfg_prdata;
  logic                        cfg_pready;

  fixed_point_pi_controller uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_err_sample (in_err_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_out (out_drive_out),
    .out_limit_hit (out_limit_hit),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller state as the block should hold it
  logic signed [GAIN_W-1:0]   kp_reg = PROP_GAIN_RST;
  logic signed [GAIN_W-1:0]   ki_reg = INTEG_GAIN_RST;
  logic signed [SAMPLE_W-1:0] lo_lim = OUT_MIN_RST;
  logic signed [SAMPLE_W-1:0] hi_lim = OUT_MAX_RST;
  logic signed [INTEG_W-1:0]  integ_acc = '0;

  drive_t drive_queue[$];
  int     err_count = 0;
  int     burst_left = 5;
  int     idle_cyc = 0;
  int     stall_cyc = 0;
  int     stall_mode = 0;

  localparam int DIR_N = 35;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 75;
  localparam int WATCHDOG_LIMIT = 5000;

  // typed expectations only where obvious; the rest come from next_drive
  dir_row_t dir_rows [0:DIR_N-1] = '{
    '{0, REG_PROP_GAIN,  16'sd0,      1, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd32767,  1, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  -16'sd32768, 1, 16'sd0,      LIMIT_NONE},
    '{1, REG_PROP_GAIN,  16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd32767,  1, 16'sd32767,  LIMIT_MAX},
    '{0, REG_PROP_GAIN,  -16'sd32768, 1, -16'sd32768, LIMIT_MIN},
    '{1, REG_PROP_GAIN,  -16'sd32768, 0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  -16'sd32768, 1, 16'sd32767,  LIMIT_MAX},
    '{0, REG_PROP_GAIN,  16'sd1,      1, -16'sd128,   LIMIT_NONE},
    '{1, REG_PROP_GAIN,  16'sd0,      0, 16'sd0,      LIMIT_NONE},
    '{1, REG_INTEG_GAIN, 16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    // drive the integrator into positive saturation, then back off
    '{0, REG_PROP_GAIN,  16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  -16'sd32768, 0, 16'sd0,      LIMIT_NONE},
    // zero integral gain clears the integrator, also when already zero
    '{1, REG_INTEG_GAIN, 16'sd0,      0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd0,      1, 16'sd0,      LIMIT_NONE},
    '{1, REG_INTEG_GAIN, 16'sd0,      0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd0,      1, 16'sd0,      LIMIT_NONE},
    '{1, REG_INTEG_GAIN, -16'sd32768, 0, 16'sd0,      LIMIT_NONE},
    '{1, REG_OUT_MIN,    -16'sd100,   0, 16'sd0,      LIMIT_NONE},
    '{1, REG_OUT_MAX,    16'sd100,    0, 16'sd0,      LIMIT_NONE},
    // anti-windup: integrator must stay at zero through both clamps
    '{0, REG_PROP_GAIN,  16'sd32767,  1, -16'sd100,   LIMIT_MIN},
    '{0, REG_PROP_GAIN,  16'sd0,      1, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  -16'sd32768, 1, 16'sd100,    LIMIT_MAX},
    // inverted limits: minimum wins
    '{1, REG_OUT_MIN,    16'sd100,    0, 16'sd0,      LIMIT_NONE},
    '{1, REG_OUT_MAX,    -16'sd100,   0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd0,      1, 16'sd100,    LIMIT_MIN},
    '{1, REG_OUT_MIN,    -16'sd32768, 0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd0,      1, -16'sd100,   LIMIT_MAX},
    '{1, REG_OUT_MAX,    16'sd32767,  0, 16'sd0,      LIMIT_NONE},
    '{1, REG_PROP_GAIN,  16'sd256,    0, 16'sd0,      LIMIT_NONE},
    '{1, REG_INTEG_GAIN, 16'sd0,      0, 16'sd0,      LIMIT_NONE},
    '{0, REG_PROP_GAIN,  16'sd1234,   1, 16'sd1234,   LIMIT_NONE},
    '{0, REG_PROP_GAIN,  -16'sd1,     1, -16'sd1,     LIMIT_NONE}
  };

  function automatic drive_t next_drive(logic signed [SAMPLE_W-1:0] e);
    longint prev, acc, y;
    drive_t r;
    prev = integ_acc;
    acc = prev + longint'(e) * longint'(ki_reg);
    if (acc > longint'(INTEG_MAX)) acc = INTEG_MAX;
    else if (acc < longint'(INTEG_MIN)) acc = INTEG_MIN;
    y = ((longint'(e) * longint'(kp_reg)) >>> PROP_SHIFT) + (acc >>> INTEG_SHIFT);
    r.limit = LIMIT_NONE;
    if (y < longint'(lo_lim)) begin
      y = lo_lim;
      r.limit = LIMIT_MIN;
      if (acc < prev) acc = prev;
    end else if (y > longint'(hi_lim)) begin
      y = hi_lim;
      r.limit = LIMIT_MAX;
      if (acc > prev) acc = prev;
    end
    integ_acc = acc[INTEG_W-1:0];
    r.drive = y[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_err(int bias);
    int mag;
    case ($urandom_range(0, 15))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2, 3, 4, 5: return SAMPLE_W'($urandom);
      default: begin
        mag = $urandom_range(0, 3000);
        if ($urandom_range(0, 4) == 0) bias = -bias;
        return SAMPLE_W'(bias * mag);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    err_count++;
    $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic wait_drained();
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic signed [15:0] val, bit junk_hi);
    logic [15:0] hi;
    hi = junk_hi ? 16'($urandom) : 16'h0000;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {hi, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN: kp_reg = val;
      REG_INTEG_GAIN: begin
        ki_reg = val;
        if (val == 0) integ_acc = '0;
      end
      REG_OUT_MIN: lo_lim = val;
      REG_OUT_MAX: hi_lim = val;
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transaction; bursts and gaps are decided here
  task automatic send_err(logic signed [SAMPLE_W-1:0] e, bit known, drive_t typed, bit last);
    drive_t r;
    int gap;
    in_valid <= 1'b1;
    in_err_sample <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = next_drive(e);
    if (known) r = typed;
    drive_queue.push_back(r);
    burst_left--;
    if (last || burst_left <= 0) begin
      if (burst_left <= 0)
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (last || gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    drive_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          err_count++;
          $display("%0t unexpected transaction: drive_out %0d limit_hit %0d",
                   $time, out_drive_out, out_limit_hit);
        end else begin
          want = drive_queue.pop_front();
          if (out_drive_out !== want.drive)
            report_mismatch("drive_out", want.drive, out_drive_out);
          if (out_limit_hit !== want.limit)
            report_mismatch("limit_hit", want.limit, out_limit_hit);
        end
      end
      stall_cyc++;
      if (stall_cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (stall_cyc % 5 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cyc <= 0;
      else
        idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic signed [15:0] lo, hi;
    int bias;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        cfg_write(dir_rows[i].idx, dir_rows[i].val, 1'b0);
      end else begin
        send_err(dir_rows[i].val, dir_rows[i].known, '{dir_rows[i].drive, dir_rows[i].lim},
                 (i == DIR_N - 1) || dir_rows[i + 1].is_cfg);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0: cfg_write(REG_PROP_GAIN, -16'sd32768, 1'($urandom_range(0, 1)));
        1: cfg_write(REG_PROP_GAIN, 16'sd32767, 1'($urandom_range(0, 1)));
        2: cfg_write(REG_PROP_GAIN, 16'sd0, 1'($urandom_range(0, 1)));
        3: cfg_write(REG_PROP_GAIN, 16'($urandom_range(0, 1024) - 512),
                     1'($urandom_range(0, 1)));
        default: cfg_write(REG_PROP_GAIN, 16'($urandom), 1'($urandom_range(0, 1)));
      endcase
      case ($urandom_range(0, 4))
        0: cfg_write(REG_INTEG_GAIN, -16'sd32768, 1'($urandom_range(0, 1)));
        1: cfg_write(REG_INTEG_GAIN, 16'sd32767, 1'($urandom_range(0, 1)));
        2: cfg_write(REG_INTEG_GAIN, 16'sd0, 1'($urandom_range(0, 1)));
        3: cfg_write(REG_INTEG_GAIN, 16'($urandom_range(0, 512) - 256),
                     1'($urandom_range(0, 1)));
        default: cfg_write(REG_INTEG_GAIN, 16'($urandom), 1'($urandom_range(0, 1)));
      endcase
      case ($urandom_range(0, 3))
        0: begin
          lo = -16'sd32768;
          hi = 16'sd32767;
        end
        1: begin
          lo = -16'($urandom_range(0, 2000));
          hi = 16'($urandom_range(0, 2000));
        end
        2: begin
          // minimum above maximum
          lo = 16'($urandom_range(0, 500));
          hi = -16'($urandom_range(1, 500));
        end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end
      endcase
      cfg_write(REG_OUT_MIN, lo, 1'($urandom_range(0, 1)));
      cfg_write(REG_OUT_MAX, hi, 1'($urandom_range(0, 1)));
      bias = $urandom_range(0, 1) ? 1 : -1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_err(pick_err(bias), 1'b0, '{16'sd0, LIMIT_NONE}, k == PHASE_ITEMS - 1);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
